// ===== hdl/scfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_pkg - servo command frame encoder shared types
// Command and result payloads, frame descriptor, opcode and register codes.
// ----------------------------------------------------------------------------
package scfe_pkg;

	// Command opcodes
	localparam logic [2:0] OP_BAUD     = 3'd0;
	localparam logic [2:0] OP_ACK_MODE = 3'd1;
	localparam logic [2:0] OP_RD_TEMP  = 3'd2;
	localparam logic [2:0] OP_RD_VOLT  = 3'd3;
	localparam logic [2:0] OP_MOVE     = 3'd4;
	localparam logic [2:0] OP_OP_MODE  = 3'd5;
	localparam logic [2:0] OP_WHEEL    = 3'd6;
	localparam logic [2:0] OP_UNUSED   = 3'd7;

	// Configuration register indexes
	localparam logic [2:0] CFG_BIG_ENDIAN = 3'd0;
	localparam logic [2:0] CFG_BAUD_ADDR  = 3'd1;
	localparam logic [2:0] CFG_ACK_ADDR   = 3'd2;
	localparam logic [2:0] CFG_TEMP_ADDR  = 3'd3;
	localparam logic [2:0] CFG_VOLT_ADDR  = 3'd4;
	localparam logic [2:0] CFG_ACC_ADDR   = 3'd5;
	localparam logic [2:0] CFG_OPM_ADDR   = 3'd6;
	localparam logic [2:0] CFG_SPEED_ADDR = 3'd7;

	// Reset values of the address registers
	localparam logic [7:0] RST_BAUD_ADDR  = 8'd6;
	localparam logic [7:0] RST_ACK_ADDR   = 8'd8;
	localparam logic [7:0] RST_TEMP_ADDR  = 8'd63;
	localparam logic [7:0] RST_VOLT_ADDR  = 8'd62;
	localparam logic [7:0] RST_ACC_ADDR   = 8'd41;
	localparam logic [7:0] RST_OPM_ADDR   = 8'd33;
	localparam logic [7:0] RST_SPEED_ADDR = 8'd46;

	// Frame constants
	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] INSTR_WRITE = 8'h03;
	localparam logic [7:0] INSTR_READ  = 8'h02;
	localparam logic [7:0] LEN_SHORT   = 8'h04;
	localparam logic [7:0] LEN_WHEEL   = 8'h05;
	localparam logic [7:0] LEN_MOVE    = 8'h0A;
	localparam logic [7:0] READ_COUNT  = 8'h01;
	localparam logic [3:0] HDR_BYTES   = 4'd4;
	localparam logic [3:0] SYNC_COUNT  = 4'd2;
	localparam logic signed [15:0] SPEED_MAX = 16'sd3000;
	localparam logic signed [15:0] SPEED_MIN = -16'sd3000;
	localparam logic [15:0] SIGN_BIT = 16'h8000;

	// Bytes held per frame: id through last data byte
	localparam int FRAME_DATA = 11;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [7:0]         servo_id;
		logic [19:0]        baud_rate;
		logic               mode_flag;
		logic [15:0]        position;
		logic [15:0]        move_time;
		logic signed [15:0] speed;
		logic [7:0]         acceleration;
	} cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic                          reject;
		logic [3:0]                    total;
		logic [FRAME_DATA-1:0][7:0]    data;
	} frame_t;

	typedef struct packed {
		logic       big_endian;
		logic [7:0] baud_addr;
		logic [7:0] ack_addr;
		logic [7:0] temp_addr;
		logic [7:0] volt_addr;
		logic [7:0] acc_addr;
		logic [7:0] opm_addr;
		logic [7:0] speed_addr;
	} cfg_regs_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic head_valid;
		logic full;
	} q_status_t;

	// Baud rate to code; valid low for unsupported rates
	function automatic logic [3:0] baud_code(input logic [19:0] rate);
		logic [3:0] r;
		begin
			unique case (rate)
				20'd1000000: r = 4'b1000;
				20'd500000:  r = 4'b1001;
				20'd250000:  r = 4'b1010;
				20'd128000:  r = 4'b1011;
				20'd115200:  r = 4'b1100;
				20'd76800:   r = 4'b1101;
				20'd57600:   r = 4'b1110;
				20'd38400:   r = 4'b1111;
				default:     r = 4'b0000;
			endcase
			return r;
		end
	endfunction

	// Word in bus order: first byte in [7:0], second in [15:8]
	function automatic logic [15:0] bus_word(input logic be, input logic [15:0] w);
		return be ? {w[7:0], w[15:8]} : w;
	endfunction

endpackage

// ===== hdl/servo_command_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_frame_encoder_core - servo bus command frame encoder
// Encodes one servo command into its bus frame, one byte per result.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------
//   command  | push / full                | cmd   (scfe_pkg::cmd_t)
//   result   | pop / empty                | res   (scfe_pkg::res_t)
//   config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A command is decoded in the cycle it is taken and queued as a descriptor;
// full rises only when QUEUE_DEPTH descriptors wait.
// The serializer emits one byte per cycle unless a result waits for pop:
// 8, 9 or 14 bytes a frame, one for a rejected baud rate, none for OP_UNUSED.
// A command's first byte passes the queue memory and the output register on
// its way to res. A stalled pop holds the output register and, once the queue
// fills, the command side. Reset clears the queue and loads register defaults.
// ----------------------------------------------------------------------------
module servo_command_frame_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  scfe_pkg::cmd_t   cmd,
	output logic             empty,
	input  logic             pop,
	output scfe_pkg::res_t   res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	scfe_pkg::frame_t                 enq_frame;
	scfe_pkg::frame_t                 head;
	scfe_pkg::q_status_t              q_status;
	logic                             enq_valid;
	logic                             deq;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	scfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.enq_valid (enq_valid),
		.enq_frame (enq_frame)
	);

	scfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push && !q_status.full && enq_valid),
		.wr_frame (enq_frame),
		.rd_en    (deq),
		.head     (head),
		.status   (q_status),
		.count    (q_count)
	);

	scfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_status.head_valid),
		.deq        (deq),
		.res        (res),
		.empty      (empty),
		.pop        (pop)
	);

	assign full = q_status.full;

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.rejected) |-> (res.last_byte && res.frame_byte == '0))
		else $error("rejection result malformed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && cmd.opcode != scfe_pkg::OP_UNUSED) |=> (q_count != '0))
		else $error("accepted command not queued");

	a_deq_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> q_status.head_valid)
		else $error("dequeue from empty queue");

endmodule

// ===== hdl/scfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_front - command decoder
// Holds the configuration registers and turns a command into a frame
// descriptor (id .. last data byte, byte count, reject flag).
// ----------------------------------------------------------------------------
module scfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	input  scfe_pkg::cmd_t        cmd,
	output logic                  enq_valid,
	output scfe_pkg::frame_t      enq_frame
);

	scfe_pkg::cfg_regs_t cfg_q;
	logic [3:0]          code;
	logic signed [15:0]  clamped;
	logic [15:0]         mag;
	logic [15:0]         wheel_word;
	logic [15:0]         pos_w;
	logic [15:0]         tim_w;
	logic [15:0]         spd_w;
	logic [15:0]         whl_w;
	logic [7:0]          len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_endian <= 1'b0;
			cfg_q.baud_addr  <= scfe_pkg::RST_BAUD_ADDR;
			cfg_q.ack_addr   <= scfe_pkg::RST_ACK_ADDR;
			cfg_q.temp_addr  <= scfe_pkg::RST_TEMP_ADDR;
			cfg_q.volt_addr  <= scfe_pkg::RST_VOLT_ADDR;
			cfg_q.acc_addr   <= scfe_pkg::RST_ACC_ADDR;
			cfg_q.opm_addr   <= scfe_pkg::RST_OPM_ADDR;
			cfg_q.speed_addr <= scfe_pkg::RST_SPEED_ADDR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scfe_pkg::CFG_BIG_ENDIAN: cfg_q.big_endian <= cfg_data[0];
				scfe_pkg::CFG_BAUD_ADDR:  cfg_q.baud_addr  <= cfg_data;
				scfe_pkg::CFG_ACK_ADDR:   cfg_q.ack_addr   <= cfg_data;
				scfe_pkg::CFG_TEMP_ADDR:  cfg_q.temp_addr  <= cfg_data;
				scfe_pkg::CFG_VOLT_ADDR:  cfg_q.volt_addr  <= cfg_data;
				scfe_pkg::CFG_ACC_ADDR:   cfg_q.acc_addr   <= cfg_data;
				scfe_pkg::CFG_OPM_ADDR:   cfg_q.opm_addr   <= cfg_data;
				scfe_pkg::CFG_SPEED_ADDR: cfg_q.speed_addr <= cfg_data;
				default: ;
			endcase
		end
	end

	// Wheel speed: clamp, then sign and magnitude
	always_comb begin
		if (cmd.speed < scfe_pkg::SPEED_MIN)
			clamped = scfe_pkg::SPEED_MIN;
		else if (cmd.speed > scfe_pkg::SPEED_MAX)
			clamped = scfe_pkg::SPEED_MAX;
		else
			clamped = cmd.speed;
		mag        = clamped[15] ? 16'(-clamped) : 16'(clamped);
		wheel_word = clamped[15] ? (mag | scfe_pkg::SIGN_BIT) : mag;
	end

	assign code  = scfe_pkg::baud_code(cmd.baud_rate);
	assign pos_w = scfe_pkg::bus_word(cfg_q.big_endian, cmd.position);
	assign tim_w = scfe_pkg::bus_word(cfg_q.big_endian, cmd.move_time);
	assign spd_w = scfe_pkg::bus_word(cfg_q.big_endian, cmd.speed);
	assign whl_w = scfe_pkg::bus_word(cfg_q.big_endian, wheel_word);

	always_comb begin
		enq_frame        = '0;
		enq_valid        = 1'b1;
		len              = scfe_pkg::LEN_SHORT;
		enq_frame.data[0] = cmd.servo_id;
		enq_frame.data[2] = scfe_pkg::INSTR_WRITE;
		unique case (cmd.opcode)
			scfe_pkg::OP_BAUD: begin
				enq_frame.data[3] = cfg_q.baud_addr;
				enq_frame.data[4] = {5'd0, code[2:0]};
				enq_frame.reject  = !code[3];
			end
			scfe_pkg::OP_ACK_MODE: begin
				enq_frame.data[3] = cfg_q.ack_addr;
				enq_frame.data[4] = {7'd0, cmd.mode_flag};
			end
			scfe_pkg::OP_RD_TEMP: begin
				enq_frame.data[2] = scfe_pkg::INSTR_READ;
				enq_frame.data[3] = cfg_q.temp_addr;
				enq_frame.data[4] = scfe_pkg::READ_COUNT;
			end
			scfe_pkg::OP_RD_VOLT: begin
				enq_frame.data[2] = scfe_pkg::INSTR_READ;
				enq_frame.data[3] = cfg_q.volt_addr;
				enq_frame.data[4] = scfe_pkg::READ_COUNT;
			end
			scfe_pkg::OP_MOVE: begin
				len                = scfe_pkg::LEN_MOVE;
				enq_frame.data[3]  = cfg_q.acc_addr;
				enq_frame.data[4]  = cmd.acceleration;
				enq_frame.data[5]  = pos_w[7:0];
				enq_frame.data[6]  = pos_w[15:8];
				enq_frame.data[7]  = tim_w[7:0];
				enq_frame.data[8]  = tim_w[15:8];
				enq_frame.data[9]  = spd_w[7:0];
				enq_frame.data[10] = spd_w[15:8];
			end
			scfe_pkg::OP_OP_MODE: begin
				enq_frame.data[3] = cfg_q.opm_addr;
				enq_frame.data[4] = {7'd0, cmd.mode_flag};
			end
			scfe_pkg::OP_WHEEL: begin
				len               = scfe_pkg::LEN_WHEEL;
				enq_frame.data[3] = cfg_q.speed_addr;
				enq_frame.data[4] = whl_w[7:0];
				enq_frame.data[5] = whl_w[15:8];
			end
			scfe_pkg::OP_UNUSED: begin
				// drop the command, nothing to send
				enq_valid = 1'b0;
			end
			default: enq_valid = 1'b0;
		endcase
		enq_frame.data[1] = len;
		enq_frame.total   = len[3:0] + scfe_pkg::HDR_BYTES;
	end

endmodule

// ===== hdl/scfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_queue - frame descriptor queue
// Small first-in first-out store between the decoder and the serializer.
// ----------------------------------------------------------------------------
module scfe_queue #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  scfe_pkg::frame_t           wr_frame,
	input  logic                       rd_en,
	output scfe_pkg::frame_t           head,
	output scfe_pkg::q_status_t        status,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scfe_pkg::frame_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign do_wr = wr_en && (count_q != CW'(DEPTH));
	assign do_rd = rd_en && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	assign head              = mem_q[rd_ptr_q];
	assign status.head_valid = (count_q != '0);
	assign status.full       = (count_q == CW'(DEPTH));
	assign count             = count_q;

endmodule

// ===== hdl/scfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfe_back - frame serializer
// Walks the head one byte per cycle unless res awaits pop: two sync bytes,
// stored bytes, inverted running sum. Output register decouples the pop side.
// ----------------------------------------------------------------------------
module scfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  scfe_pkg::frame_t    head,
	input  logic                head_valid,
	output logic                deq,
	output scfe_pkg::res_t      res,
	output logic                empty,
	input  logic                pop
);

	logic [3:0]     idx_q;
	logic [7:0]     sum_q;
	logic           out_valid_q;
	scfe_pkg::res_t res_q;
	logic [3:0]     off;
	logic           load;
	logic           is_last;
	scfe_pkg::res_t nxt;

	assign off     = idx_q - scfe_pkg::SYNC_COUNT;
	assign load    = head_valid && (!out_valid_q || pop);
	assign is_last = head.reject || (idx_q == head.total - 4'd1);
	assign deq     = load && is_last;

	always_comb begin
		nxt.last_byte = is_last;
		nxt.rejected  = head.reject;
		if (head.reject)
			nxt.frame_byte = '0;
		else if (idx_q < scfe_pkg::SYNC_COUNT)
			nxt.frame_byte = scfe_pkg::SYNC_BYTE;
		else if (is_last)
			nxt.frame_byte = ~sum_q;
		else if (off < 4'(scfe_pkg::FRAME_DATA))
			nxt.frame_byte = head.data[off];
		else
			nxt.frame_byte = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + 4'd1;
					// checksum covers id through the last data byte
					if (idx_q >= scfe_pkg::SYNC_COUNT)
						sum_q <= sum_q + nxt.frame_byte;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= nxt;
	end

	assign res   = res_q;
	assign empty = !out_valid_q;

endmodule
